// ===== rtl/pdas_pkg.sv =====
// Shared types and fixed field widths for the phoneme duration and stretch block.
`default_nettype none

package pdas_pkg;

    // Fixed field widths of the item and result beats
    localparam int unsigned PHONE_W = 9;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned DUR_W   = 13;
    // Width wide enough to compare an index against the largest phoneme limit
    localparam int unsigned CMP_W   = 13;

    // Operation codes
    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_COUNT   = 2'd1,
        OP_STRETCH = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    // Sequencer states
    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_LOOK,
        S_DIV
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/pdas_div.sv =====
// Restoring divider: fraction (num << FB) / den for num below den, one bit per cycle.
`default_nettype none

module pdas_div #(
    parameter int unsigned DW = 13,
    parameter int unsigned FB = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [FB-1:0]      o_quot
);

    localparam int unsigned CW = $clog2(FB + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [FB-1:0] r_quot;

    logic [DW:0]   w_shift;
    logic [DW:0]   w_diff;
    logic          w_ge;

    // One restoring step: double the remainder, subtract where it fits
    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign w_diff  = w_shift - {1'b0, r_den};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(FB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DW-1:0] : w_shift[DW-1:0];
            r_quot <= {r_quot[FB-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== rtl/phoneme_duration_and_stretch.sv =====
// Top level: phoneme duration table, run tracking and in-run position fraction.
//
// Usage
//   Items enter on start/i_operation/i_phone_index and are taken at an edge where
//   start is high and busy is low. Each item gives exactly one result beat on
//   o_position_fraction/o_duration_count/o_index_error, marked by o_done for
//   one cycle; the receiver cannot stall it.
//   phone_count sits at byte address 0 of the APB port (pready tied high).
// Operation flow (one item at a time; busy is high while an item is in work)
//   Index error, index zero: result registered, no table access, busy stays low.
//   Count: one table read then write-back. Read: one table read.
//   Stretch: table read, then, unless the entry is zero or the run count has
//   reached it, the bit-serial divider gives one quotient bit a cycle.
//   Clear: registered result, then a sweep of all MAX_PHONES entries zeroes the
//   duration memory, one entry per cycle, with busy held high.
// Reset
//   Run state clears, phone_count returns to 256 and the same sweep over all
//   MAX_PHONES entries runs before the first item is taken.
`default_nettype none

module phoneme_duration_and_stretch
    import pdas_pkg::*;
#(
    parameter int unsigned MAX_PHONES    = 256,
    parameter int unsigned MAX_FRAMES    = 4096,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // item channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_operation,
    input  wire logic [PHONE_W-1:0] i_phone_index,
    // result channel
    output logic                    o_done,
    output logic [FRAC_W-1:0]       o_position_fraction,
    output logic [DUR_W-1:0]        o_duration_count,
    output logic                    o_index_error,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int unsigned AW = $clog2(MAX_PHONES);
    localparam int unsigned DW = $clog2(MAX_FRAMES + 1);
    localparam int unsigned FB = FRACTION_BITS;
    localparam int unsigned FRAC_LIM = (FB > 16) ? 65535 : ((1 << FB) - 1);

    // Registers
    t_state             r_state, n_state;
    logic [PHONE_W-1:0] r_phone_count;
    t_op                r_op, n_op;
    logic [PHONE_W-1:0] r_idx, n_idx;
    logic [DW-1:0]      r_run, n_run;
    logic [PHONE_W-1:0] r_prev, n_prev;
    logic               r_first, n_first;
    logic [AW-1:0]      r_sweep, n_sweep;
    logic               r_done, n_done;
    logic [FRAC_W-1:0]  r_frac, n_frac;
    logic [DUR_W-1:0]   r_dur, n_dur;
    logic               r_err, n_err;

    // Duration memory
    logic [DW-1:0]      mem [MAX_PHONES];
    logic [DW-1:0]      r_rd_data;
    logic               w_re;
    logic [AW-1:0]      w_raddr;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [DW-1:0]      w_wdata;

    // Item decode
    logic               w_accept;
    t_op                w_op;
    logic               w_over;
    logic [PHONE_W-1:0] w_slot_in;
    logic [PHONE_W-1:0] w_slot_reg;

    // Stretch and count arithmetic
    logic [DW-1:0]      w_run_next;
    logic               w_sat;
    logic [DW-1:0]      w_cnt_inc;

    // Divider
    logic               w_div_start;
    logic               w_div_done;
    logic [FB-1:0]      w_div_quot;
    logic [FB-1:0]      w_quot_lim;

    logic               w_cfg_wr;

    assign w_accept   = start && (r_state == S_IDLE);
    assign w_op       = t_op'(i_operation);
    assign w_over     = (CMP_W'(i_phone_index) > CMP_W'(r_phone_count)) ||
                        (CMP_W'(i_phone_index) > CMP_W'(MAX_PHONES));
    assign w_slot_in  = i_phone_index - PHONE_W'(1);
    assign w_slot_reg = r_idx - PHONE_W'(1);

    // Run counter restarts on a new index or the first frame, else saturating step
    always_comb begin
        if (r_first || (r_idx != r_prev)) begin
            w_run_next = '0;
        end else if (r_run < DW'(MAX_FRAMES)) begin
            w_run_next = r_run + DW'(1);
        end else begin
            w_run_next = r_run;
        end
    end
    assign w_sat     = (w_run_next >= r_rd_data);
    assign w_cnt_inc = (r_rd_data < DW'(MAX_FRAMES)) ? (r_rd_data + DW'(1)) : r_rd_data;

    // Quotient limit where the fraction is wider than the result field
    assign w_quot_lim = (w_div_quot > FB'(FRAC_LIM)) ? FB'(FRAC_LIM) : w_div_quot;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_SWEEP: begin
                if (r_sweep == AW'(MAX_PHONES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    if (w_op == OP_CLEAR) begin
                        n_state = S_SWEEP;
                    end else if (!w_over && (i_phone_index != '0)) begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if ((r_op == OP_STRETCH) && (r_rd_data != '0) && !w_sat) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (w_div_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_op        = r_op;
        n_idx       = r_idx;
        n_run       = r_run;
        n_prev      = r_prev;
        n_first     = r_first;
        n_sweep     = r_sweep;
        n_done      = 1'b0;
        n_frac      = r_frac;
        n_dur       = r_dur;
        n_err       = r_err;
        w_re        = 1'b0;
        w_raddr     = AW'(w_slot_in);
        w_we        = 1'b0;
        w_waddr     = AW'(w_slot_reg);
        w_wdata     = w_cnt_inc;
        w_div_start = 1'b0;
        unique case (r_state)
            S_SWEEP: begin
                w_we    = 1'b1;
                w_waddr = r_sweep;
                w_wdata = '0;
                n_sweep = r_sweep + AW'(1);
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_op  = w_op;
                    n_idx = i_phone_index;
                    if (w_op == OP_CLEAR) begin
                        n_done  = 1'b1;
                        n_frac  = '0;
                        n_dur   = '0;
                        n_err   = 1'b0;
                        n_run   = '0;
                        n_prev  = '0;
                        n_first = 1'b1;
                        n_sweep = '0;
                    end else if (w_over) begin
                        n_done = 1'b1;
                        n_frac = '0;
                        n_dur  = '0;
                        n_err  = 1'b1;
                    end else if (i_phone_index == '0) begin
                        n_done = 1'b1;
                        n_frac = '0;
                        n_dur  = '0;
                        n_err  = 1'b0;
                        if (w_op == OP_STRETCH) begin
                            n_run   = '0;
                            n_prev  = '0;
                            n_first = 1'b0;
                        end
                    end else begin
                        w_re = 1'b1;
                    end
                end
            end
            S_LOOK: begin
                n_frac = '0;
                n_dur  = '0;
                n_err  = 1'b0;
                unique case (r_op)
                    OP_COUNT: begin
                        w_we   = 1'b1;
                        n_done = 1'b1;
                    end
                    OP_READ: begin
                        n_dur  = DUR_W'(r_rd_data);
                        n_done = 1'b1;
                    end
                    OP_STRETCH: begin
                        n_prev  = r_idx;
                        n_first = 1'b0;
                        if (r_rd_data == '0) begin
                            n_done = 1'b1;
                        end else begin
                            n_run = w_run_next;
                            if (w_sat) begin
                                n_frac = FRAC_W'(FRAC_LIM);
                                n_done = 1'b1;
                            end else begin
                                w_div_start = 1'b1;
                            end
                        end
                    end
                    default: n_done = 1'b1;
                endcase
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_frac = FRAC_W'(w_quot_lim);
                    n_dur  = '0;
                    n_err  = 1'b0;
                    n_done = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_run   <= '0;
            r_prev  <= '0;
            r_first <= 1'b1;
            r_sweep <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_run   <= n_run;
            r_prev  <= n_prev;
            r_first <= n_first;
            r_sweep <= n_sweep;
            r_done  <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_idx  <= n_idx;
        r_frac <= n_frac;
        r_dur  <= n_dur;
        r_err  <= n_err;
    end

    // Duration memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (w_re) r_rd_data <= mem[w_raddr];
    end

    // Bit-serial fraction divider
    pdas_div #(
        .DW (DW),
        .FB (FB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_run_next),
        .i_den   (r_rd_data),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // Configuration register
    assign w_cfg_wr = psel && penable && pwrite && pready && !paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phone_count <= PHONE_W'(256);
        end else if (w_cfg_wr) begin
            r_phone_count <= pwdata[PHONE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(r_phone_count);

    // Result beat
    assign busy                = (r_state != S_IDLE);
    assign o_done              = r_done;
    assign o_position_fraction = r_frac;
    assign o_duration_count    = r_dur;
    assign o_index_error       = r_err;

endmodule

`default_nettype wire
